FILE: sv/bmma_pkg.sv
// ----------------------------------------------------------------------------
// bmma_pkg
// Shared types and constants of the block matrix multiply-accumulate unit.
// ----------------------------------------------------------------------------
package bmma_pkg;

  localparam int MaxN  = 16;
  localparam int IdxW  = $clog2(MaxN);
  localparam int AddrW = 2 * IdxW;
  localparam int Depth = MaxN * MaxN;
  localparam int ElemW = 16;
  localparam int ProdW = 2 * ElemW;
  localparam int AccW  = 48;
  localparam int SizeW = 5;
  localparam int KindW = 3;

  localparam logic [SizeW-1:0] SizeReset = SizeW'(16);

  typedef enum logic [KindW-1:0] {
    KIND_WR_A  = 3'd0,
    KIND_WR_B  = 3'd1,
    KIND_CLR_C = 3'd2,
    KIND_MAC   = 3'd3,
    KIND_RD_C  = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_RUN,
    SEQ_DRAIN
  } seq_state_e;

  typedef struct packed {
    logic            valid;
    logic [IdxW-1:0] i;
    logic [IdxW-1:0] k;
    logic [IdxW-1:0] j;
  } issue_t;

  typedef struct packed {
    logic pipe_busy;
    logic stage1_valid;
    logic stage2_valid;
  } mac_status_t;

endpackage

FILE: sv/bmma_seq.sv
// ----------------------------------------------------------------------------
// bmma_seq
// Pass sequencer: steps the i, k, j indices of one multiply-accumulate pass
// and waits for the accumulate pipeline to drain.
// ----------------------------------------------------------------------------
module bmma_seq
  import bmma_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [SizeW-1:0] size_i,
  input  mac_status_t      status_i,
  output issue_t           issue_o,
  output logic             busy_o
);

  localparam logic [SizeW-1:0] MaxNSize = SizeW'(MaxN);

  seq_state_e      state_q, state_d;
  logic [IdxW-1:0] i_q, k_q, j_q;
  logic [SizeW-1:0] n_eff;
  logic [SizeW-1:0] n_less;
  logic [IdxW-1:0] last;
  logic            j_end, k_end, i_end;

  assign n_eff  = (size_i > MaxNSize) ? MaxNSize : size_i;
  assign n_less = n_eff - SizeW'(1);
  assign last   = n_less[IdxW-1:0];
  assign j_end  = (j_q == last);
  assign k_end  = (k_q == last);
  assign i_end  = (i_q == last);

  always_comb begin
    state_d = state_q;
    case (state_q)
      SEQ_IDLE: begin
        if (start_i && (n_eff != '0)) begin
          state_d = SEQ_RUN;
        end
      end
      SEQ_RUN: begin
        if (i_end && k_end && j_end) begin
          state_d = SEQ_DRAIN;
        end
      end
      SEQ_DRAIN: begin
        if (!status_i.pipe_busy) begin
          state_d = SEQ_IDLE;
        end
      end
      default: begin
        state_d = SEQ_IDLE;
      end
    endcase
  end

  always_comb begin
    issue_o.valid = 1'b0;
    issue_o.i     = i_q;
    issue_o.k     = k_q;
    issue_o.j     = j_q;
    busy_o        = 1'b1;
    case (state_q)
      SEQ_IDLE: begin
        busy_o = 1'b0;
      end
      SEQ_RUN: begin
        issue_o.valid = 1'b1;
      end
      SEQ_DRAIN: begin
        busy_o = 1'b1;
      end
      default: begin
        busy_o = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SEQ_IDLE;
      i_q     <= '0;
      k_q     <= '0;
      j_q     <= '0;
    end else begin
      state_q <= state_d;
      if (state_q != SEQ_RUN) begin
        i_q <= '0;
        k_q <= '0;
        j_q <= '0;
      end else if (!j_end) begin
        j_q <= j_q + IdxW'(1);
      end else begin
        j_q <= '0;
        if (!k_end) begin
          k_q <= k_q + IdxW'(1);
        end else begin
          k_q <= '0;
          i_q <= i_q + IdxW'(1);
        end
      end
    end
  end

endmodule

FILE: sv/bmma_mac.sv
// ----------------------------------------------------------------------------
// bmma_mac
// A, B and C stores with the multiply-accumulate pipeline: read, multiply,
// saturating add and write back, with forwarding of recent C updates.
// ----------------------------------------------------------------------------
module bmma_mac
  import bmma_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  issue_t                  issue_i,
  input  logic                    wr_a_i,
  input  logic                    wr_b_i,
  input  logic                    clr_i,
  input  logic                    rd_i,
  input  logic [AddrW-1:0]        addr_i,
  input  logic signed [ElemW-1:0] value_i,
  output logic signed [AccW-1:0]  rd_data_o,
  output mac_status_t             status_o
);

  localparam logic signed [AccW:0] AccMax = (AccW+1)'({1'b0, {(AccW-1){1'b1}}});
  localparam logic signed [AccW:0] AccMin = -AccMax - (AccW+1)'(1);

  logic signed [ElemW-1:0] a_mem [Depth];
  logic signed [ElemW-1:0] b_mem [Depth];
  logic signed [AccW-1:0]  c_mem [Depth];
  logic [Depth-1:0]        c_valid_q;

  logic signed [ElemW-1:0] a_q, b_q;
  logic signed [AccW-1:0]  c_q;
  logic                    rd_valid_q;

  logic                    s1_valid_q;
  logic [AddrW-1:0]        s1_addr_q;
  logic                    s2_valid_q;
  logic [AddrW-1:0]        s2_addr_q;
  logic signed [AccW-1:0]  s2_acc_q;
  logic signed [ProdW-1:0] s2_prod_q;
  logic                    wb_valid_q;
  logic [AddrW-1:0]        wb_addr_q;
  logic signed [AccW-1:0]  wb_data_q;

  logic [AddrW-1:0]        a_raddr, b_raddr, c_raddr;
  logic                    c_ren;
  logic signed [AccW:0]    sum_wide;
  logic signed [AccW-1:0]  sum_sat;
  logic signed [AccW-1:0]  c_cur;
  logic signed [ProdW-1:0] prod;

  assign a_raddr = {issue_i.i, issue_i.k};
  assign b_raddr = {issue_i.k, issue_i.j};
  assign c_raddr = issue_i.valid ? {issue_i.i, issue_i.j} : addr_i;
  assign c_ren   = issue_i.valid || rd_i;

  always_ff @(posedge clk_i) begin
    if (wr_a_i) begin
      a_mem[addr_i] <= value_i;
    end
    if (issue_i.valid) begin
      a_q <= a_mem[a_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_b_i) begin
      b_mem[addr_i] <= value_i;
    end
    if (issue_i.valid) begin
      b_q <= b_mem[b_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_valid_q) begin
      c_mem[s2_addr_q] <= sum_sat;
    end
    if (c_ren) begin
      c_q <= c_mem[c_raddr];
    end
  end

  assign prod     = a_q * b_q;
  assign sum_wide = (AccW+1)'(s2_acc_q) + (AccW+1)'(s2_prod_q);

  always_comb begin
    if (sum_wide > AccMax) begin
      sum_sat = AccMax[AccW-1:0];
    end else if (sum_wide < AccMin) begin
      sum_sat = AccMin[AccW-1:0];
    end else begin
      sum_sat = sum_wide[AccW-1:0];
    end
  end

  always_comb begin
    if (s2_valid_q && (s2_addr_q == s1_addr_q)) begin
      c_cur = sum_sat;
    end else if (wb_valid_q && (wb_addr_q == s1_addr_q)) begin
      c_cur = wb_data_q;
    end else if (c_valid_q[s1_addr_q]) begin
      c_cur = c_q;
    end else begin
      c_cur = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_addr_q <= {issue_i.i, issue_i.j};
    s2_addr_q <= s1_addr_q;
    s2_acc_q  <= c_cur;
    s2_prod_q <= prod;
    wb_addr_q <= s2_addr_q;
    wb_data_q <= sum_sat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      wb_valid_q <= 1'b0;
      rd_valid_q <= 1'b0;
      c_valid_q  <= '0;
    end else begin
      s1_valid_q <= issue_i.valid;
      s2_valid_q <= s1_valid_q;
      wb_valid_q <= s2_valid_q;
      if (rd_i) begin
        rd_valid_q <= c_valid_q[addr_i];
      end
      if (clr_i) begin
        c_valid_q <= '0;
      end else if (s2_valid_q) begin
        c_valid_q[s2_addr_q] <= 1'b1;
      end
    end
  end

  assign rd_data_o             = rd_valid_q ? c_q : '0;
  assign status_o.pipe_busy    = s1_valid_q || s2_valid_q;
  assign status_o.stage1_valid = s1_valid_q;
  assign status_o.stage2_valid = s2_valid_q;

endmodule

FILE: sv/block_matrix_multiply_accumulate.sv
// ----------------------------------------------------------------------------
// block_matrix_multiply_accumulate
// Square block matrix multiply-accumulate, C += A * B, on Q4.12 elements with
// a saturating Q24.24 accumulator.
// ----------------------------------------------------------------------------
// Each input word writes an element of A or B, clears C, starts one
// multiply-accumulate pass, or reads one element of C. A read passes through
// the C store register and then the output register. Writes, clears and
// reads run at one word per cycle unless a read waits on a stalled output. A
// pass with an effective block size n (block_size, at most 16) holds off the
// input until its updates drain: a single multiply-accumulate lane reads,
// updates and writes back one C element per cycle through the C store. C is
// cleared at reset and by the clear command at once, with no sweep of the store.
// ----------------------------------------------------------------------------
module block_matrix_multiply_accumulate
  import bmma_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [KindW-1:0]        kind_i,
  input  logic [IdxW-1:0]         row_i,
  input  logic [IdxW-1:0]         col_i,
  input  logic signed [ElemW-1:0] value_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [AccW-1:0]  c_value_o,
  output logic [IdxW-1:0]         out_row_o,
  output logic [IdxW-1:0]         out_col_o,
  input  logic                    cfg_we_i,
  input  logic [SizeW-1:0]        cfg_data_i
);

  logic [SizeW-1:0]       size_q;
  logic                   seq_busy;
  issue_t                 issue;
  mac_status_t            status;
  logic                   accept;
  logic                   is_wr_a, is_wr_b, is_clr, is_mac, is_rd;
  logic signed [AccW-1:0] rd_data;

  logic                   pend_q, pend_d;
  logic [IdxW-1:0]        pend_row_q, pend_col_q;
  logic                   out_valid_q, out_valid_d;
  logic                   load;
  logic signed [AccW-1:0] c_value_q;
  logic [IdxW-1:0]        out_row_q, out_col_q;

  assign in_stall_o = seq_busy || (pend_q && out_valid_q && out_stall_i);
  assign accept     = in_valid_i && !in_stall_o;

  assign is_wr_a = accept && (kind_e'(kind_i) == KIND_WR_A);
  assign is_wr_b = accept && (kind_e'(kind_i) == KIND_WR_B);
  assign is_clr  = accept && (kind_e'(kind_i) == KIND_CLR_C);
  assign is_mac  = accept && (kind_e'(kind_i) == KIND_MAC);
  assign is_rd   = accept && (kind_e'(kind_i) == KIND_RD_C);

  bmma_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (is_mac),
    .size_i   (size_q),
    .status_i (status),
    .issue_o  (issue),
    .busy_o   (seq_busy)
  );

  bmma_mac u_mac (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .issue_i   (issue),
    .wr_a_i    (is_wr_a),
    .wr_b_i    (is_wr_b),
    .clr_i     (is_clr),
    .rd_i      (is_rd),
    .addr_i    ({row_i, col_i}),
    .value_i   (value_i),
    .rd_data_o (rd_data),
    .status_o  (status)
  );

  assign load        = pend_q && (!out_valid_q || !out_stall_i);
  assign pend_d      = is_rd || (pend_q && !load);
  assign out_valid_d = load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q      <= SizeReset;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        size_q <= cfg_data_i;
      end
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (is_rd) begin
      pend_row_q <= row_i;
      pend_col_q <= col_i;
    end
    if (load) begin
      c_value_q <= rd_data;
      out_row_q <= pend_row_q;
      out_col_q <= pend_col_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign c_value_o   = c_value_q;
  assign out_row_o   = out_row_q;
  assign out_col_o   = out_col_q;

endmodule

FILE: bench/block_matrix_multiply_accumulate_tb.sv
// ----------------------------------------------------------------------------
// block_matrix_multiply_accumulate_tb
// Self-checking bench for the block matrix multiply-accumulate unit.
// ----------------------------------------------------------------------------
// A driver feeds words from a queue and a monitor predicts every C read from
// its own copy of A, B and C, then compares each returned word with the
// oldest prediction. A directed opening covers the value extremes, every
// command, spare kinds and elements outside the block in use. Random phases
// follow, each with a block size from a list holding zero and a size above the
// maximum, with sender gaps and receiver stalls that change from phase to phase.
// ----------------------------------------------------------------------------
module block_matrix_multiply_accumulate_tb;
  import bmma_pkg::*;

  localparam int WatchdogLimit = 20000;
  localparam int PhaseWords = 90;
  localparam int NumPhases = 12;
  localparam logic [KindW-1:0] KindSpareLo = KindW'(KIND_RD_C) + 1'b1;
  localparam logic [KindW-1:0] KindSpareHi = '1;
  localparam longint AccMax = (longint'(1) <<< (AccW - 1)) - 1;
  localparam longint AccMin = -AccMax - 1;
  localparam logic [SizeW-1:0] PhaseSizes [NumPhases] =
    '{1, 0, 3, 5, 2, 8, 16, 4, 31, 12, 1, 6};

  typedef struct {
    logic [KindW-1:0]        kind;
    logic [IdxW-1:0]         row;
    logic [IdxW-1:0]         col;
    logic signed [ElemW-1:0] value;
    bit                      hold;
  } mm_word_t;

  typedef struct {
    logic signed [AccW-1:0] c_value;
    logic [IdxW-1:0]        row;
    logic [IdxW-1:0]        col;
  } c_read_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid_i = 1'b0;
  logic                    in_stall_o;
  logic [KindW-1:0]        kind_i = '0;
  logic [IdxW-1:0]         row_i = '0;
  logic [IdxW-1:0]         col_i = '0;
  logic signed [ElemW-1:0] value_i = '0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic signed [AccW-1:0]  c_value_o;
  logic [IdxW-1:0]         out_row_o;
  logic [IdxW-1:0]         out_col_o;
  logic                    cfg_we_i = 1'b0;
  logic [SizeW-1:0]        cfg_data_i = '0;

  mm_word_t word_q[$];
  c_read_t  c_reads_q[$];

  logic signed [ElemW-1:0] a_model [Depth];
  logic signed [ElemW-1:0] b_model [Depth];
  logic signed [AccW-1:0]  c_model [Depth];
  logic [SizeW-1:0]        model_size = SizeReset;

  bit               a_written [Depth];
  bit               b_written [Depth];
  logic [SizeW-1:0] gen_size = SizeReset;
  bit               mac_queued = 1'b0;

  int idle_pct = 0;
  int stall_pct = 0;
  int reads_sent = 0;
  int results_seen = 0;
  int mismatches = 0;
  int quiet_cycles = 0;

  bit       word_taken;
  int       outstanding;
  mm_word_t next_word;
  c_read_t  want;

  block_matrix_multiply_accumulate uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .kind_i     (kind_i),
    .row_i      (row_i),
    .col_i      (col_i),
    .value_i    (value_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .c_value_o  (c_value_o),
    .out_row_o  (out_row_o),
    .out_col_o  (out_col_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic int effective_size(input logic [SizeW-1:0] size);
    return (size > MaxN) ? MaxN : int'(size);
  endfunction

  task automatic run_mac_model();
    int n;
    longint prod;
    longint sum;
    n = effective_size(model_size);
    for (int i = 0; i < n; i++) begin
      for (int k = 0; k < n; k++) begin
        for (int j = 0; j < n; j++) begin
          prod = longint'(a_model[i*MaxN+k]) * longint'(b_model[k*MaxN+j]);
          sum = longint'(c_model[i*MaxN+j]) + prod;
          if (sum > AccMax) begin
            sum = AccMax;
          end else if (sum < AccMin) begin
            sum = AccMin;
          end
          c_model[i*MaxN+j] = AccW'(sum);
        end
      end
    end
  endtask

  task automatic apply_word(input logic [KindW-1:0] kind, input logic [IdxW-1:0] row,
                            input logic [IdxW-1:0] col, input logic signed [ElemW-1:0] value);
    case (kind)
      KIND_WR_A: begin
        a_model[{row, col}] = value;
      end
      KIND_WR_B: begin
        b_model[{row, col}] = value;
      end
      KIND_CLR_C: begin
        foreach (c_model[i]) c_model[i] = '0;
      end
      KIND_MAC: begin
        run_mac_model();
      end
      KIND_RD_C: begin
        c_reads_q.push_back('{c_value: c_model[{row, col}], row: row, col: col});
      end
      default: begin
      end
    endcase
  endtask

  // Driver: a presented word holds until accepted; a held word waits for
  // every outstanding C read to come back first.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      word_taken = in_valid_i && !in_stall_o;
      outstanding = reads_sent - results_seen +
                    ((word_taken && kind_i == KIND_RD_C) ? 1 : 0);
      if (word_taken && kind_i == KIND_RD_C) begin
        reads_sent <= reads_sent + 1;
      end
      if (in_valid_i && !word_taken) begin
      end else if (word_q.size() > 0 && $urandom_range(99) >= idle_pct &&
                   !(word_q[0].hold && outstanding != 0)) begin
        next_word = word_q.pop_front();
        in_valid_i <= 1'b1;
        kind_i <= next_word.kind;
        row_i <= next_word.row;
        col_i <= next_word.col;
        value_i <= next_word.value;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) begin
        model_size = cfg_data_i;
      end
      if (in_valid_i && !in_stall_o) begin
        apply_word(kind_i, row_i, col_i, value_i);
      end
      if (out_valid_o && !out_stall_i) begin
        results_seen <= results_seen + 1;
        if (c_reads_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Unexpected C word: %0d at (%0d,%0d)", c_value_o, out_row_o,
                     out_col_o);
          end
        end else begin
          want = c_reads_q.pop_front();
          if (c_value_o !== want.c_value || out_row_o !== want.row ||
              out_col_o !== want.col) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("C word mismatch: expected %0d at (%0d,%0d), got %0d at (%0d,%0d)",
                       want.c_value, want.row, want.col, c_value_o, out_row_o,
                       out_col_o);
            end
          end
        end
      end
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WatchdogLimit) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  function automatic logic signed [ElemW-1:0] pick_value();
    case ($urandom_range(9))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return '0;
      3: return '1;
      default: return ElemW'($urandom);
    endcase
  endfunction

  task automatic push_word(input logic [KindW-1:0] kind, input logic [IdxW-1:0] row,
                           input logic [IdxW-1:0] col, input logic signed [ElemW-1:0] value,
                           input bit hold);
    if (kind == KIND_WR_A) begin
      a_written[{row, col}] = 1'b1;
    end
    if (kind == KIND_WR_B) begin
      b_written[{row, col}] = 1'b1;
    end
    if (kind == KIND_MAC) begin
      mac_queued = 1'b1;
    end
    word_q.push_back('{kind: kind, row: row, col: col, value: value, hold: hold});
  endtask

  // A pass must never read an operand that was never written.
  task automatic fill_operands(inout int made);
    int n;
    n = effective_size(gen_size);
    for (int i = 0; i < n; i++) begin
      for (int k = 0; k < n; k++) begin
        if (!a_written[i*MaxN+k]) begin
          push_word(KIND_WR_A, IdxW'(i), IdxW'(k), pick_value(), 1'b0);
          made++;
        end
        if (!b_written[i*MaxN+k]) begin
          push_word(KIND_WR_B, IdxW'(i), IdxW'(k), pick_value(), 1'b0);
          made++;
        end
      end
    end
  endtask

  task automatic gen_phase(input int words);
    int made;
    int roll;
    logic [IdxW-1:0] row;
    logic [IdxW-1:0] col;
    bit hold;
    made = 0;
    while (made < words) begin
      roll = $urandom_range(99);
      row = IdxW'($urandom);
      col = IdxW'($urandom);
      hold = (made == 0) || ($urandom_range(49) == 0);
      if (roll < 27) begin
        push_word(KIND_WR_A, row, col, pick_value(), hold);
      end else if (roll < 54) begin
        push_word(KIND_WR_B, row, col, pick_value(), hold);
      end else if (roll < 85) begin
        push_word(KIND_RD_C, row, col, pick_value(), hold);
      end else if (roll < 92) begin
        fill_operands(made);
        push_word(KIND_MAC, row, col, pick_value(), hold);
      end else if (roll < 95) begin
        push_word(KIND_CLR_C, row, col, pick_value(), hold);
      end else begin
        push_word(KindW'($urandom_range(KindSpareLo, KindSpareHi)), row, col,
                  pick_value(), hold);
        made--;
      end
      made++;
    end
  endtask

  task automatic wait_drained();
    do begin
      @(negedge clk_i);
    end while (word_q.size() != 0 || in_valid_i || c_reads_q.size() != 0);
  endtask

  // A pass yields no word, so after one the unit may still be busy.
  task automatic settle();
    int n;
    n = effective_size(gen_size);
    repeat (mac_queued ? n * n * n + 16 : 8) @(posedge clk_i);
    mac_queued = 1'b0;
  endtask

  task automatic write_block_size(input logic [SizeW-1:0] size);
    wait_drained();
    settle();
    cfg_data_i <= size;
    cfg_we_i <= 1'b1;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    gen_size = size;
    @(negedge clk_i);
  endtask

  initial begin
    foreach (c_model[i]) c_model[i] = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_block_size(2);

    push_word(KIND_RD_C, 0, 0, '0, 1'b0);
    push_word(KIND_RD_C, 15, 15, '1, 1'b0);
    push_word(KIND_WR_A, 0, 0, 16'sh7FFF, 1'b0);
    push_word(KIND_WR_A, 0, 1, 16'sh8000, 1'b0);
    push_word(KIND_WR_A, 1, 0, 16'sh0000, 1'b0);
    push_word(KIND_WR_A, 1, 1, 16'shFFFF, 1'b0);
    push_word(KIND_WR_B, 0, 0, 16'sh8000, 1'b0);
    push_word(KIND_WR_B, 0, 1, 16'sh7FFF, 1'b0);
    push_word(KIND_WR_B, 1, 0, 16'sh8000, 1'b0);
    push_word(KIND_WR_B, 1, 1, 16'sh1000, 1'b0);
    push_word(KIND_WR_A, 15, 15, 16'sh7FFF, 1'b0);
    push_word(KIND_WR_B, 15, 15, 16'sh8000, 1'b0);
    push_word(KIND_MAC, 0, 0, '0, 1'b0);
    push_word(KIND_RD_C, 0, 0, '0, 1'b0);
    push_word(KIND_RD_C, 0, 1, '0, 1'b0);
    push_word(KIND_RD_C, 1, 0, '0, 1'b0);
    push_word(KIND_RD_C, 1, 1, '0, 1'b0);
    push_word(KIND_RD_C, 15, 15, '0, 1'b0);
    push_word(KindSpareLo, 3, 3, 16'sh1234, 1'b0);
    push_word(KindSpareHi, 15, 0, 16'sh8000, 1'b0);
    push_word(KIND_MAC, 15, 15, '1, 1'b0);
    push_word(KIND_RD_C, 1, 1, '0, 1'b0);
    push_word(KIND_CLR_C, 0, 0, '0, 1'b0);
    push_word(KIND_RD_C, 0, 0, '0, 1'b1);
    push_word(KIND_RD_C, 1, 1, '0, 1'b0);

    for (int p = 0; p < NumPhases; p++) begin
      write_block_size(PhaseSizes[p]);
      case (p % 4)
        0: begin
          idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct = 55;
          stall_pct = 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct = 55;
        end
        default: begin
          idle_pct = 25;
          stall_pct = 25;
        end
      endcase
      gen_phase(PhaseWords);
    end

    wait_drained();
    settle();
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/bmma_pkg.sv
sv/bmma_seq.sv
sv/bmma_mac.sv
sv/block_matrix_multiply_accumulate.sv
bench/block_matrix_multiply_accumulate_tb.sv
